// ===== rtl/itd_pkg.sv =====
package itd_pkg;

    // binary operand and decimal digit storage
    localparam int BIN_W       = 64;
    localparam int STEP_W      = $clog2(BIN_W);
    localparam int DIGITS      = 20;
    localparam int BCD_W       = 4 * DIGITS;
    localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

    // field width limit and character codes
    localparam int         WIDTH_W    = 6;
    localparam int         CHAR_W     = 8;
    localparam logic [5:0] MAX_WIDTH  = 6'd32;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // input mode codes
    localparam logic OP_UNSIGNED = 1'b0;
    localparam logic OP_SIGNED   = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SCAN,
        ST_PAD,
        ST_DIGITS
    } state_t;

endpackage

// ===== rtl/integer_to_decimal_text.sv =====
// channel  | signals                              | handshake
// ---------+--------------------------------------+-------------------------------
// command  | op, value, min_width, pad_char       | taken on start while busy low
// result   | out_char, last                       | strobe high for one cycle
//
// a number first passes through the shift-and-add-3 binary to decimal unit, one
// bit per cycle, then leading zero digits are skipped, then pad characters and
// digits follow, one character leaving per cycle.
// a minus sign leaves in the first conversion cycle.
// reset clears the sequencer and the result strobe; the receiver cannot stall.
module integer_to_decimal_text (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [63:0] value,
    input  logic [5:0]  min_width,
    input  logic [7:0]  pad_char,
    output logic        strobe,
    output logic [7:0]  out_char,
    output logic        last
);

    itd_pkg::state_t                        state_reg, state_next;
    logic [itd_pkg::BIN_W-1:0]              bin_reg, bin_next;
    logic [itd_pkg::BCD_W-1:0]              bcd_reg, bcd_next;
    logic [itd_pkg::STEP_W-1:0]             step_reg, step_next;
    logic [itd_pkg::DIGIT_CNT_W-1:0]        ndig_reg, ndig_next;
    logic [itd_pkg::WIDTH_W-1:0]            pad_reg, pad_next;
    logic [itd_pkg::WIDTH_W-1:0]            width_reg, width_next;
    logic [itd_pkg::CHAR_W-1:0]             padch_reg, padch_next;
    logic [itd_pkg::CHAR_W-1:0]             out_char_reg, out_char_next;
    logic                                   last_reg, last_next;
    logic                                   strobe_reg, strobe_next;

    logic [itd_pkg::BCD_W-1:0]              bcd_adj;
    logic [3:0]                             top_digit;
    logic [itd_pkg::WIDTH_W-1:0]            ndig_ext;
    logic                                   negative;

    // add-3 correction on every digit ahead of the shift
    always_comb
    begin
        for (int d = 0; d < itd_pkg::DIGITS; d++)
        begin
            if (bcd_reg[4*d +: 4] >= 4'd5)
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4] + 4'd3;
            else
                bcd_adj[4*d +: 4] = bcd_reg[4*d +: 4];
        end
    end

    assign top_digit = bcd_reg[itd_pkg::BCD_W-1 -: 4];
    assign ndig_ext  = {{(itd_pkg::WIDTH_W-itd_pkg::DIGIT_CNT_W){1'b0}}, ndig_reg};
    assign negative  = (op == itd_pkg::OP_SIGNED) && value[itd_pkg::BIN_W-1];

    // sequencer and datapath next values
    always_comb
    begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        step_next     = step_reg;
        ndig_next     = ndig_reg;
        pad_next      = pad_reg;
        width_next    = width_reg;
        padch_next    = padch_reg;
        out_char_next = out_char_reg;
        last_next     = 1'b0;
        strobe_next   = 1'b0;

        case (state_reg)
            itd_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    bin_next   = negative ? (~value + 64'd1) : value;
                    bcd_next   = '0;
                    step_next  = '0;
                    padch_next = pad_char;
                    width_next = (min_width > itd_pkg::MAX_WIDTH) ? itd_pkg::MAX_WIDTH
                                                                  : min_width;
                    // sign beat goes out right away
                    if (negative)
                    begin
                        strobe_next   = 1'b1;
                        out_char_next = itd_pkg::CHAR_MINUS;
                    end
                    state_next = itd_pkg::ST_CONVERT;
                end
            end

            itd_pkg::ST_CONVERT:
            begin
                bcd_next  = {bcd_adj[itd_pkg::BCD_W-2:0], bin_reg[itd_pkg::BIN_W-1]};
                bin_next  = {bin_reg[itd_pkg::BIN_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == {itd_pkg::STEP_W{1'b1}})
                begin
                    ndig_next  = itd_pkg::DIGIT_CNT_W'(itd_pkg::DIGITS);
                    state_next = itd_pkg::ST_SCAN;
                end
            end

            itd_pkg::ST_SCAN:
            begin
                // drop leading zero digits, keep at least one
                if (top_digit == 4'd0 && ndig_reg > 1)
                begin
                    bcd_next  = {bcd_reg[itd_pkg::BCD_W-5:0], 4'd0};
                    ndig_next = ndig_reg - 1'b1;
                end
                else if (width_reg > ndig_ext)
                begin
                    pad_next   = width_reg - ndig_ext;
                    state_next = itd_pkg::ST_PAD;
                end
                else
                begin
                    state_next = itd_pkg::ST_DIGITS;
                end
            end

            itd_pkg::ST_PAD:
            begin
                strobe_next   = 1'b1;
                out_char_next = padch_reg;
                pad_next      = pad_reg - 1'b1;
                if (pad_reg == 1)
                    state_next = itd_pkg::ST_DIGITS;
            end

            itd_pkg::ST_DIGITS:
            begin
                strobe_next   = 1'b1;
                out_char_next = itd_pkg::CHAR_ZERO + {4'd0, top_digit};
                bcd_next      = {bcd_reg[itd_pkg::BCD_W-5:0], 4'd0};
                ndig_next     = ndig_reg - 1'b1;
                if (ndig_reg == 1)
                begin
                    last_next  = 1'b1;
                    state_next = itd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = itd_pkg::ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= itd_pkg::ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        step_reg     <= step_next;
        ndig_reg     <= ndig_next;
        pad_reg      <= pad_next;
        width_reg    <= width_next;
        padch_reg    <= padch_next;
        out_char_reg <= out_char_next;
        last_reg     <= last_next;
    end

    assign busy     = (state_reg != itd_pkg::ST_IDLE);
    assign strobe   = strobe_reg;
    assign out_char = out_char_reg;
    assign last     = last_reg;

endmodule

// ===== test/tb_integer_to_decimal_text.sv =====
module tb_integer_to_decimal_text;

    // one character beat as it leaves the block
    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_beat_t;

    // one directed number; an empty text means the formatter works it out
    typedef struct {
        logic        mode;
        logic [63:0] raw;
        logic [5:0]  wid;
        logic [7:0]  pad;
        string       text;
    } number_row_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [63:0] value;
    logic [5:0]  min_width;
    logic [7:0]  pad_char;
    logic        strobe;
    logic [7:0]  out_char;
    logic        last;

    char_beat_t  pending_chars[$];
    number_row_t directed_rows[$];
    int          mismatch_count;
    int          sender_idle_pct;

    integer_to_decimal_text u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .op        (op),
        .value     (value),
        .min_width (min_width),
        .pad_char  (pad_char),
        .strobe    (strobe),
        .out_char  (out_char),
        .last      (last)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void add_char(logic [7:0] c);
        char_beat_t beat;
        beat.ch   = c;
        beat.last = 1'b0;
        pending_chars.push_back(beat);
    endfunction

    // expected characters of one number: sign, padding, then digits msd first
    function automatic void format_number(logic mode, logic [63:0] raw, logic [5:0] wid,
                                          logic [7:0] pad);
        logic [63:0] mag;
        logic [7:0]  digs [20];
        int          nd;
        int          field;
        mag   = raw;
        nd    = 0;
        field = (wid > itd_pkg::MAX_WIDTH) ? int'(itd_pkg::MAX_WIDTH) : int'(wid);
        if (mode == itd_pkg::OP_SIGNED && raw[63])
        begin
            add_char(itd_pkg::CHAR_MINUS);
            mag = ~raw + 64'd1;
        end
        // least significant digit first, zero gives one digit
        do
        begin
            digs[nd] = itd_pkg::CHAR_ZERO + 8'(mag % 64'd10);
            mag      = mag / 64'd10;
            nd++;
        end while (mag != 64'd0);
        for (int i = nd; i < field; i++)
            add_char(pad);
        for (int i = nd - 1; i >= 0; i--)
            add_char(digs[i]);
        pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    // expected characters typed in as text
    function automatic void load_text(string s);
        for (int i = 0; i < s.len(); i++)
            add_char(s[i]);
        pending_chars[pending_chars.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [63:0] power_of_ten(int k);
        logic [63:0] p;
        p = 64'd1;
        for (int i = 0; i < k; i++)
            p = p * 64'd10;
        return p;
    endfunction

    // random values biased toward digit count and sign boundaries
    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0: v = {$urandom, $urandom};
            1: v = 64'($urandom_range(0, 999));
            2: v = power_of_ten($urandom_range(0, 19)) + 64'($urandom_range(0, 2)) - 64'd1;
            3: v = -64'($urandom_range(1, 999));
            4: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            5: v = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            6: v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
            default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        return v;
    endfunction

    function automatic logic [5:0] pick_width();
        if ($urandom_range(0, 9) < 8)
            return 6'($urandom_range(0, 32));
        return 6'($urandom_range(33, 63));
    endfunction

    // send one number beat, with optional idle cycles in front
    task automatic send_number(logic mode, logic [63:0] raw, logic [5:0] wid, logic [7:0] pad,
                               string text);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start     <= 1'b0;
            op        <= 1'($urandom);
            value     <= {$urandom, $urandom};
            min_width <= 6'($urandom);
            pad_char  <= 8'($urandom);
            @(posedge clk);
        end
        start     <= 1'b1;
        op        <= mode;
        value     <= raw;
        min_width <= wid;
        pad_char  <= pad;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (text.len() == 0)
            format_number(mode, raw, wid, pad);
        else
            load_text(text);
    endtask

    // character checker
    always @(posedge clk)
    begin : check_chars
        char_beat_t want;
        if (rst_n === 1'b1 && strobe === 1'b1)
        begin
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected char expected none actual %h last %b",
                         $time, out_char, last);
                mismatch_count++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    $display("%0t: out_char expected %h actual %h", $time, want.ch, out_char);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $display("%0t: last expected %b actual %b", $time, want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        mismatch_count  = 0;
        sender_idle_pct = 22;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        op        <= itd_pkg::OP_UNSIGNED;
        value     <= 64'd0;
        min_width <= 6'd0;
        pad_char  <= 8'h20;

        // directed numbers: zero, extremes, padding and saturation
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd0, 6'd0, 8'h20, "0"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd0, 6'd1, 8'h20, "0"});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'd0, 6'd5, 8'h2A, "****0"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 8'h20,
                                  "18446744073709551615"});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 8'h20,
                                  "-1"});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'h8000_0000_0000_0000, 6'd0, 8'h20,
                                  "-9223372036854775808"});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 8'h20,
                                  "9223372036854775807"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'h8000_0000_0000_0000, 6'd0, 8'h20,
                                  "9223372036854775808"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd10_000_000_000_000_000_000,
                                  6'd0, 8'h20, "10000000000000000000"});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, -64'd5, 6'd3, 8'h20, "-  5"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd12345, 6'd5, 8'h2E, "12345"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd12345, 6'd3, 8'h2E, "12345"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd9, 6'd2, 8'h30, "09"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd10, 6'd0, 8'h20, "10"});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd1, 6'd32, 8'h30, ""});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd7, 6'd63, 8'h78, ""});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd7, 6'd33, 8'h78, ""});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'd42, 6'd4, 8'h00, ""});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'd9_999_999_999_999_999_999,
                                  6'd0, 8'h20, ""});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd33, 8'h23,
                                  ""});
        directed_rows.push_back('{itd_pkg::OP_UNSIGNED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd32, 8'hFF,
                                  ""});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'h8000_0000_0000_0000, 6'd32, 8'h2E,
                                  ""});
        directed_rows.push_back('{itd_pkg::OP_SIGNED, 64'h8000_0000_0000_0000, 6'd63, 8'h55,
                                  ""});

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_number(directed_rows[i].mode, directed_rows[i].raw, directed_rows[i].wid,
                        directed_rows[i].pad, directed_rows[i].text);

        // random numbers in three idle phases
        for (int ph = 0; ph < 3; ph++)
        begin
            sender_idle_pct = (ph == 0) ? 22 : (ph == 1) ? 84 : 0;
            repeat ((ph == 2) ? 150 : 160)
                send_number(1'($urandom), pick_value(), pick_width(), 8'($urandom), "");
        end
        start <= 1'b0;

        // drain and watch for stray characters
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/itd_pkg.sv
rtl/integer_to_decimal_text.sv
test/tb_integer_to_decimal_text.sv
